// ===== rtl/dlsc_pkg.sv =====
package dlsc_pkg;

   // character codes
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;
   localparam logic [7:0] CH_A       = 8'h61;
   localparam logic [7:0] CH_E       = 8'h65;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_Y       = 8'h79;
   localparam logic [7:0] CH_NONE    = 8'h00;

   // word match progress: 1..3 walk "nan", 4..11 walk "infinity" (length + 3)
   localparam logic [3:0] WP_NONE      = 4'd0;
   localparam logic [3:0] WP_NAN_N     = 4'd1;
   localparam logic [3:0] WP_NAN_NA    = 4'd2;
   localparam logic [3:0] WP_NAN_DONE  = 4'd3;
   localparam logic [3:0] WP_INF_I     = 4'd4;
   localparam logic [3:0] WP_INF_DONE  = 4'd6;
   localparam logic [3:0] WP_INFTY_LST = 4'd10;
   localparam logic [3:0] WP_INFTY_END = 4'd11;

   localparam logic [1:0] DOTS_MAX     = 2'd2;
   localparam logic [1:0] EXP_DIG_MAX  = 2'd3;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_SIGN     = 3'd1,
      PH_WORD     = 3'd2,
      PH_COEF     = 3'd3,
      PH_EXP_E    = 3'd4,
      PH_EXP_SIGN = 3'd5,
      PH_EXP_DIG  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      V_KEEP    = 2'd0,
      V_CLEAR   = 2'd1,
      V_INVALID = 2'd2
   } verdict_type;

   // one input word as held in the input register
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_word_type;

   // control between the output side and the scanner
   typedef struct packed {
      logic        fire;
      logic        last;
      verdict_type verdict;
   } scan_out_type;

endpackage

// ===== rtl/decimal_literal_syntax_checker_top.sv =====
// Path: a last character goes into the input register, and its verdict is loaded
//   into the result register once that register is free (input register, then result register).
// Throughput: one character per cycle, set by the scanner's state update; only a
//   last character waits, while an untaken verdict blocks the result register.
// Reset: synchronous, active high; clears both registers' valid bits and puts the
//   scanner at the start of a string.
module decimal_literal_syntax_checker_top
   import dlsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict
);

   logic         word_valid;
   req_word_type word;
   logic         out_free;
   logic         fire;
   scan_out_type scan_out;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   verdict_type  rsp_verdict_ff;

   // a character that ends no string needs no result slot, so only
   // the last character of a string waits on the result register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = word_valid && (!word.last || out_free);

   dlsc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .pop        (fire),
      .word_valid (word_valid),
      .word       (word)
   );

   dlsc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .word     (word),
      .scan_out (scan_out)
   );

   // result register: load on a string end, drop once the word is taken
   always_comb begin
      priority if (scan_out.fire && scan_out.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_out.fire && scan_out.last) begin
         rsp_verdict_ff <= scan_out.verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef SYNTH
   // stall only while a word sits in the input register
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> word_valid)
      else $error("input stalled with empty input register");

   // a string end stays put while the result register is blocked
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      word_valid && word.last && rsp_valid_ff && rsp_stall |=> word_valid && word.last)
      else $error("last character lost while result blocked");

   // a string end always shows up as a result
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire && word.last |=> rsp_valid_ff)
      else $error("string end produced no result");

   // a character inside a string never creates a result
   a_mid_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(fire && word.last) |=> !rsp_valid_ff)
      else $error("result appeared without a string end");
`endif

endmodule

// ===== rtl/dlsc_input_stage.sv =====
module dlsc_input_stage
   import dlsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_ch,
   input  logic         req_last,
   input  logic         pop,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   assign req_stall  = valid_ff && !pop;
   assign load       = req_valid && !req_stall;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload unless a new word comes in
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.ch   <= req_ch;
         word_ff.last <= req_last;
      end
   end

endmodule

// ===== rtl/dlsc_scan.sv =====
module dlsc_scan
   import dlsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type word,
   output scan_out_type scan_out
);

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  word_progress;
      logic [1:0]  dots_seen;
      logic        saw_digit;
      logic        all_zero;
      logic        bad;
      logic [1:0]  exp_digits;
   } scan_state_type;

   localparam scan_state_type STATE_RESET = '{
      phase:         PH_START,
      word_progress: WP_NONE,
      dots_seen:     2'd0,
      saw_digit:     1'b0,
      all_zero:      1'b1,
      bad:           1'b0,
      exp_digits:    2'd0
   };

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type nxt;
   logic [7:0]     c;

   function automatic logic is_digit(input logic [7:0] x);
      return (x >= CH_ZERO) && (x <= CH_NINE);
   endfunction

   // expected next letter of the word under match
   function automatic logic [7:0] word_char(input logic [3:0] wp);
      logic [7:0] r;
      unique case (wp)
         4'd1:    r = CH_A;
         4'd2:    r = CH_N;
         4'd4:    r = CH_N;
         4'd5:    r = CH_F;
         4'd6:    r = CH_I;
         4'd7:    r = CH_N;
         4'd8:    r = CH_I;
         4'd9:    r = CH_T;
         4'd10:   r = CH_Y;
         default: r = CH_NONE;
      endcase
      return r;
   endfunction

   function automatic scan_state_type take_coef(input scan_state_type s,
                                                input logic [7:0] x);
      scan_state_type r;
      r = s;
      priority if (x == CH_DOT) begin
         if (r.dots_seen < DOTS_MAX) begin
            r.dots_seen = r.dots_seen + 2'd1;
         end
         if (r.dots_seen > 2'd1) begin
            r.bad = 1'b1;
         end
      end else if (is_digit(x)) begin
         r.saw_digit = 1'b1;
         if (x != CH_ZERO) begin
            r.all_zero = 1'b0;
         end
      end else if (r.saw_digit && x == CH_E) begin
         r.phase = PH_EXP_E;
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   function automatic scan_state_type take_first(input scan_state_type s,
                                                 input logic [7:0] x);
      scan_state_type r;
      r = s;
      priority if (x == CH_N) begin
         r.phase         = PH_WORD;
         r.word_progress = WP_NAN_N;
      end else if (x == CH_I) begin
         r.phase         = PH_WORD;
         r.word_progress = WP_INF_I;
      end else if (is_digit(x) || x == CH_DOT) begin
         r.phase = PH_COEF;
         r = take_coef(r, x);
      end else begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   function automatic verdict_type judge(input scan_state_type s);
      verdict_type v;
      v = V_INVALID;
      if (!s.bad) begin
         unique case (s.phase)
            PH_WORD: begin
               if (s.word_progress == WP_NAN_DONE || s.word_progress == WP_INF_DONE ||
                   s.word_progress == WP_INFTY_END) begin
                  v = V_KEEP;
               end
            end
            PH_COEF, PH_EXP_DIG: begin
               if (s.saw_digit) begin
                  v = s.all_zero ? V_CLEAR : V_KEEP;
               end
            end
            default: v = V_INVALID;
         endcase
      end
      return v;
   endfunction

   // fold A..Z to lower case
   always_comb begin
      c = word.ch;
      if (word.ch >= CH_UPPER_A && word.ch <= CH_UPPER_Z) begin
         c = word.ch + CASE_SHIFT;
      end
   end

   always_comb begin
      nxt = state_ff;
      if (!state_ff.bad) begin
         unique case (state_ff.phase)
            PH_START: begin
               if (c == CH_PLUS || c == CH_MINUS) begin
                  nxt.phase = PH_SIGN;
               end else begin
                  nxt = take_first(state_ff, c);
               end
            end
            PH_SIGN: nxt = take_first(state_ff, c);
            PH_WORD: begin
               if (((state_ff.word_progress >= WP_NAN_N &&
                     state_ff.word_progress <= WP_NAN_NA) ||
                    (state_ff.word_progress >= WP_INF_I &&
                     state_ff.word_progress <= WP_INFTY_LST)) &&
                   c == word_char(state_ff.word_progress)) begin
                  nxt.word_progress = state_ff.word_progress + 4'd1;
               end else begin
                  nxt.bad = 1'b1;
               end
            end
            PH_COEF: nxt = take_coef(state_ff, c);
            PH_EXP_E: begin
               priority if (c == CH_PLUS || c == CH_MINUS) begin
                  nxt.phase = PH_EXP_SIGN;
               end else if (is_digit(c)) begin
                  nxt.phase      = PH_EXP_DIG;
                  nxt.exp_digits = 2'd1;
               end else begin
                  nxt.bad = 1'b1;
               end
            end
            PH_EXP_SIGN: begin
               if (is_digit(c)) begin
                  nxt.phase      = PH_EXP_DIG;
                  nxt.exp_digits = 2'd1;
               end else begin
                  nxt.bad = 1'b1;
               end
            end
            PH_EXP_DIG: begin
               if (is_digit(c)) begin
                  if (state_ff.exp_digits < EXP_DIG_MAX) begin
                     nxt.exp_digits = state_ff.exp_digits + 2'd1;
                  end
               end else begin
                  nxt.bad = 1'b1;
               end
            end
            default: nxt.bad = 1'b1;
         endcase
      end
   end

   // drop back to the start of a string after its last character
   always_comb begin
      priority if (!fire) begin
         state_in = state_ff;
      end else if (word.last) begin
         state_in = STATE_RESET;
      end else begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   assign scan_out.fire    = fire;
   assign scan_out.last    = word.last;
   assign scan_out.verdict = judge(nxt);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

import dlsc_pkg::*;

// Scoreboard for the literal checker: tracks the scan of the string that is
// currently streaming in and keeps the verdicts still owed by the block.
class verdict_scoreboard;

   phase_type   phase;
   bit          in_nan;
   int          word_len;
   int          dots;
   bit          saw_digit;
   bit          all_zero;
   bit          broken;
   string       nan_word = "nan";
   string       inf_word = "infinity";
   verdict_type expected_verdicts[$];
   int          failures;

   function new();
      failures = 0;
      clear_scan();
   endfunction

   function void clear_scan();
      phase     = PH_START;
      in_nan    = 1'b0;
      word_len  = 0;
      dots      = 0;
      saw_digit = 1'b0;
      all_zero  = 1'b1;
      broken    = 1'b0;
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function void coef_char(logic [7:0] c);
      if (c == CH_DOT) begin
         dots++;
         if (dots > 1) broken = 1'b1;
      end else if (is_digit(c)) begin
         saw_digit = 1'b1;
         if (c != CH_ZERO) all_zero = 1'b0;
      end else if (saw_digit && c == CH_E) begin
         phase = PH_EXP_E;
      end else begin
         broken = 1'b1;
      end
   endfunction

   function void first_char(logic [7:0] c);
      if (c == CH_N || c == CH_I) begin
         phase    = PH_WORD;
         in_nan   = (c == CH_N);
         word_len = 1;
      end else if (is_digit(c) || c == CH_DOT) begin
         phase = PH_COEF;
         coef_char(c);
      end else begin
         broken = 1'b1;
      end
   endfunction

   function void word_char(logic [7:0] c);
      int          limit;
      logic [7:0]  want;
      limit = in_nan ? 3 : 8;
      if (word_len >= limit) begin
         broken = 1'b1;
      end else begin
         want = in_nan ? nan_word[word_len] : inf_word[word_len];
         if (c == want) word_len++;
         else broken = 1'b1;
      end
   endfunction

   function verdict_type verdict_now();
      if (broken) return V_INVALID;
      case (phase)
         PH_WORD: begin
            if (in_nan ? (word_len == 3) : (word_len == 3 || word_len == 8)) return V_KEEP;
            return V_INVALID;
         end
         PH_COEF, PH_EXP_DIG: begin
            if (!saw_digit) return V_INVALID;
            return all_zero ? V_CLEAR : V_KEEP;
         end
         default: return V_INVALID;
      endcase
   endfunction

   // Advance the scan by one accepted word; queue a verdict on the last one.
   function void note_word(logic [7:0] raw, logic last);
      logic [7:0] c;
      c = raw;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_SHIFT;
      if (!broken) begin
         case (phase)
            PH_START: begin
               if (c == CH_PLUS || c == CH_MINUS) phase = PH_SIGN;
               else first_char(c);
            end
            PH_SIGN: first_char(c);
            PH_WORD: word_char(c);
            PH_COEF: coef_char(c);
            PH_EXP_E: begin
               if (c == CH_PLUS || c == CH_MINUS) phase = PH_EXP_SIGN;
               else if (is_digit(c)) phase = PH_EXP_DIG;
               else broken = 1'b1;
            end
            PH_EXP_SIGN: begin
               if (is_digit(c)) phase = PH_EXP_DIG;
               else broken = 1'b1;
            end
            PH_EXP_DIG: if (!is_digit(c)) broken = 1'b1;
            default: broken = 1'b1;
         endcase
      end
      if (last) begin
         expected_verdicts.push_back(verdict_now());
         clear_scan();
      end
   endfunction

   function void fail(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
   endfunction

   function void check_verdict(logic [1:0] got);
      verdict_type want;
      if (expected_verdicts.size() == 0) begin
         fail($sformatf("verdict %0d with none expected", got));
      end else begin
         want = expected_verdicts.pop_front();
         if (got !== want) fail($sformatf("verdict expected %0d, got %0d", want, got));
      end
   endfunction

   function int waiting();
      return expected_verdicts.size();
   endfunction
endclass

module testbench;
   import dlsc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
   localparam int PHASE_CHARS  = 100;   // random characters per idling phase

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch    = 8'h00;
   logic       req_last  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_verdict;

   verdict_scoreboard board;

   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   bit         hold_request  = 1'b0;
   int         quiet_cycles  = 0;
   int         sent_chars    = 0;
   logic [7:0] txt[$];   // string being built for the next send

   decimal_literal_syntax_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

   always #5 clock = ~clock;

   initial board = new();

   // Monitor both channels at each edge. Values read here are the ones the
   // block saw at the edge, since all driving is done with nonblocking writes.
   // Also run the watchdog: count edges with no handshake on either side.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) board.note_word(req_ch, req_last);
         if (rsp_valid && !rsp_stall) board.check_verdict(rsp_verdict);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: stall at random at the current rate; on request hold stall
   // high for a long stretch so the block backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Send the string in txt one word per handshake; mark the final word last.
   // Hold the payload until the block takes it; idle at random between words.
   task automatic send_text();
      for (int i = 0; i < txt.size(); i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_ch    <= txt[i];
         req_last  <= (i == txt.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      sent_chars += txt.size();
   endtask

   task automatic send_literal(string s);
      txt.delete();
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      send_text();
   endtask

   // Drop valid and wait until every owed verdict has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.waiting() != 0) @(posedge clock);
   endtask

   task automatic add_digit();
      logic [7:0] d;
      d = ($urandom_range(99) < 35) ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9));
      txt.push_back(d);
   endtask

   // Build a well-formed number most of the time: optional sign, digits with an
   // optional dot, then an optional exponent. Zeros are favored so that
   // all-zero coefficients come up often.
   task automatic build_number();
      int n_int;
      int n_frac;
      int n_exp;
      if ($urandom_range(1)) txt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      n_int = $urandom_range(4);
      for (int i = 0; i < n_int; i++) add_digit();
      if ($urandom_range(1)) begin
         txt.push_back(CH_DOT);
         n_frac = $urandom_range(3);
         for (int i = 0; i < n_frac; i++) add_digit();
      end
      if ($urandom_range(99) < 40) begin
         txt.push_back($urandom_range(1) ? CH_E : CH_E - CASE_SHIFT);
         if ($urandom_range(1)) txt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
         n_exp = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 3);
         for (int i = 0; i < n_exp; i++) add_digit();
      end
   endtask

   // Build one of the special words in mixed case; sometimes cut it short
   // or run it on by one letter.
   task automatic build_word();
      string      w;
      int         pick;
      int         len;
      logic [7:0] c;
      if ($urandom_range(99) < 40) txt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      pick = $urandom_range(2);
      w    = (pick == 0) ? "nan" : (pick == 1) ? "inf" : "infinity";
      len  = w.len();
      if ($urandom_range(99) < 20) len = $urandom_range(1, w.len());
      for (int i = 0; i < len; i++) begin
         c = w[i];
         if ($urandom_range(1)) c = c - CASE_SHIFT;
         txt.push_back(c);
      end
      if ($urandom_range(99) < 15) txt.push_back(w[$urandom_range(w.len() - 1)]);
   endtask

   // Replace one character, half the time with a syntax character.
   task automatic corrupt_text();
      int         pos;
      logic [7:0] c;
      pos = $urandom_range(txt.size() - 1);
      case ($urandom_range(7))
         0: c = CH_DOT;
         1: c = CH_E;
         2: c = CH_PLUS;
         3: c = CH_MINUS;
         default: c = 8'($urandom_range(255));
      endcase
      txt[pos] = c;
   endtask

   task automatic send_random_string();
      int kind;
      int n;
      txt.delete();
      kind = $urandom_range(99);
      if (kind < 45) begin
         build_number();
      end else if (kind < 70) begin
         build_word();
      end else if (kind < 90) begin
         if ($urandom_range(1)) build_number();
         else build_word();
         if (txt.size() == 0) add_digit();
         corrupt_text();
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) txt.push_back(8'($urandom_range(255)));
      end
      if (txt.size() == 0) add_digit();
      send_text();
   endtask

   // One idling phase: set the rates, optionally ask for the long hold-off,
   // stream random strings, then drain.
   task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (with_hold) hold_request = 1'b1;
      target = sent_chars + PHASE_CHARS;
      while (sent_chars < target) send_random_string();
      drain();
   endtask

   initial begin
      // Hold reset at the start, then release it once.
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings: sign only, lone dot, dot without a digit, bare
      // exponent, the words in mixed case, zero coefficient with exponent,
      // a letter start, a high byte, and a plain keep.
      send_literal("-");
      send_literal(".");
      send_literal(".e");
      send_literal("1e+");
      send_literal("NaN");
      send_literal("iNF");
      send_literal("0.E7");
      send_literal("x");
      txt.delete();
      txt.push_back(8'hff);
      send_text();
      send_literal("5");
      send_literal("Infinity");
      drain();

      // Random phases. Run the long hold-off while the sender keeps offering.
      run_phase(0, 0, 1'b1);
      run_phase(88, 0, 1'b0);
      run_phase(0, 88, 1'b0);
      run_phase(28, 28, 1'b0);

      // Stop stalling, drain, and wait for stray verdicts before the final check.
      rsp_stall_pct = 0;
      drain();
      repeat (8) @(posedge clock);
      if (board.waiting() != 0) board.fail($sformatf("%0d verdicts never came", board.waiting()));

      if (board.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
